[rtl/core/idx_hsp_pkg.sv]
// Shared types, codes and type-byte helpers for the IDX header stream parser.
package idx_hsp_pkg;

  // Default running-count width
  localparam int unsigned CountWidthDefault = 32;

  // Data type bytes carried in magic byte 2
  localparam logic [7:0] TypeU8  = 8'h08;
  localparam logic [7:0] TypeS8  = 8'h09;
  localparam logic [7:0] TypeI16 = 8'h0B;
  localparam logic [7:0] TypeI32 = 8'h0C;
  localparam logic [7:0] TypeF32 = 8'h0D;
  localparam logic [7:0] TypeF64 = 8'h0E;

  // Byte classes
  localparam logic [2:0] ClsMagic   = 3'd0;
  localparam logic [2:0] ClsDim     = 3'd1;
  localparam logic [2:0] ClsPayload = 3'd2;
  localparam logic [2:0] ClsTrail   = 3'd3;
  localparam logic [2:0] ClsIgnored = 3'd4;

  // Parse status codes
  localparam logic [2:0] StBusy       = 3'd0;
  localparam logic [2:0] StDone       = 3'd1;
  localparam logic [2:0] StShortMagic = 3'd2;
  localparam logic [2:0] StShortDims  = 3'd3;
  localparam logic [2:0] StShortPay   = 3'd4;
  localparam logic [2:0] StBadType    = 3'd5;

  // One result word
  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  byte_class;
    logic [2:0]  parse_status;
    logic [7:0]  type_code;
    logic [3:0]  element_size;
    logic [7:0]  dim_count;
    logic [31:0] element_count;
    logic        count_overflow;
    logic [34:0] payload_offset;
  } res_t;

  // Bytes per element; zero for an unknown type
  function automatic logic [3:0] elem_size(input logic [7:0] t);
    logic [3:0] s;
    s = 4'd0;
    case (t)
      TypeU8, TypeS8:   s = 4'd1;
      TypeI16:          s = 4'd2;
      TypeI32, TypeF32: s = 4'd4;
      TypeF64:          s = 4'd8;
      default:          s = 4'd0;
    endcase
    return s;
  endfunction

  // log2 of the element size, for valid types
  function automatic logic [1:0] elem_shift(input logic [7:0] t);
    logic [1:0] s;
    s = 2'd0;
    case (t)
      TypeI16:          s = 2'd1;
      TypeI32, TypeF32: s = 2'd2;
      TypeF64:          s = 2'd3;
      default:          s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

[rtl/core/idx_hsp_if.sv]
// Valid/ready channel interfaces for the parser's byte input and result output.
interface idx_hsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_file;
  logic       end_of_file;

  modport source (output valid, output in_byte, output start_of_file,
                  output end_of_file, input ready);
  modport sink   (input valid, input in_byte, input start_of_file,
                  input end_of_file, output ready);
endinterface

interface idx_hsp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [2:0]  byte_class;
  logic [2:0]  parse_status;
  logic [7:0]  type_code;
  logic [3:0]  element_size;
  logic [7:0]  dim_count;
  logic [31:0] element_count;
  logic        count_overflow;
  logic [34:0] payload_offset;

  modport source (output valid, output out_byte, output byte_class, output parse_status,
                  output type_code, output element_size, output dim_count,
                  output element_count, output count_overflow, output payload_offset,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_class, input parse_status,
                  input type_code, input element_size, input dim_count,
                  input element_count, input count_overflow, input payload_offset,
                  output ready);
endinterface

[rtl/core/idx_hsp_skid.sv]
// Two-entry output stage: result register plus skid register.
module idx_hsp_skid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  idx_hsp_pkg::res_t  data_i,
  output logic               ready_o,
  output logic               valid_o,
  output idx_hsp_pkg::res_t  data_o,
  input  logic               ready_i
);
  import idx_hsp_pkg::*;

  logic out_v_q, skid_v_q;
  res_t out_q, skid_q;
  logic pop, load_out;

  assign ready_o  = !skid_v_q;
  assign valid_o  = out_v_q;
  assign data_o   = out_q;
  assign pop      = out_v_q && ready_i;
  assign load_out = !out_v_q || pop;

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (load_out) begin
      out_v_q  <= skid_v_q || push_i;
      skid_v_q <= 1'b0;
    end else if (push_i) begin
      skid_v_q <= 1'b1;
    end
  end

  // Move payload words
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= skid_v_q ? skid_q : data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  // A word never sits in the skid register with the result register empty
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid word without result word");

  // A stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !ready_i) |=> (out_v_q && $stable(out_q)))
    else $error("stalled result word changed");

endmodule

[rtl/core/idx_hsp_parse.sv]
// Parse state and per-byte classification for the IDX header stream.
module idx_hsp_parse #(
  parameter int unsigned CountWidth = idx_hsp_pkg::CountWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  logic [7:0]        in_byte_i,
  input  logic              sof_i,
  input  logic              eof_i,
  output idx_hsp_pkg::res_t res_o
);
  import idx_hsp_pkg::*;

  localparam int unsigned AccW = CountWidth + 32;
  localparam int unsigned CntW = CountWidth + 3;

  localparam logic [2:0] PhMagic   = 3'd0;
  localparam logic [2:0] PhDims    = 3'd1;
  localparam logic [2:0] PhPayload = 3'd2;
  localparam logic [2:0] PhDone    = 3'd3;
  localparam logic [2:0] PhError   = 3'd4;

  logic [2:0]            phase_q, phase_e, phase_d;
  logic [1:0]            pos_q, pos_e, pos_d;
  logic [7:0]            dims_q, dims_e, dims_d;
  logic [7:0]            type_q, type_e, type_d;
  logic [7:0]            dimc_q, dimc_e, dimc_d;
  logic [CountWidth-1:0] prod_q, prod_e, prod_d;
  logic                  ovf_q, ovf_e, ovf_d;
  logic [CntW-1:0]       cnt_q, cnt_e, cnt_d;
  logic [2:0]            err_q, err_e, err_d;
  logic [AccW-1:0]       acc_q, acc_d, acc_base, acc_next;
  logic [CountWidth+7:0] part;
  logic [CntW-1:0]       len_e, len_q, offs;
  logic [2:0]            cls, status;
  logic [CountWidth+31:0] prod_ext;
  logic [CntW+34:0]       offs_ext;

  // Apply a start mark before parsing the byte
  always_comb begin
    phase_e = sof_i ? PhMagic : phase_q;
    pos_e   = sof_i ? 2'd0 : pos_q;
    dims_e  = sof_i ? 8'd0 : dims_q;
    type_e  = sof_i ? 8'd0 : type_q;
    dimc_e  = sof_i ? 8'd0 : dimc_q;
    prod_e  = sof_i ? CountWidth'(1) : prod_q;
    ovf_e   = sof_i ? 1'b0 : ovf_q;
    cnt_e   = sof_i ? '0 : cnt_q;
    err_e   = sof_i ? StBusy : err_q;
  end

  // Payload length is the count shifted by log2 of the element size
  assign len_e = CntW'(prod_e) << elem_shift(type_e);
  assign len_q = CntW'(prod_q) << elem_shift(type_q);

  // Multiply the running count by one dimension byte, most significant first
  assign acc_base = (pos_e == 2'd0) ? '0 : acc_q;
  assign part     = (CountWidth+8)'(prod_e) * (CountWidth+8)'(in_byte_i);
  assign acc_next = (acc_base << 8) + AccW'(part);

  // Next state and byte class
  always_comb begin
    phase_d = phase_e;
    pos_d   = pos_e;
    dims_d  = dims_e;
    type_d  = type_e;
    dimc_d  = dimc_e;
    prod_d  = prod_e;
    ovf_d   = ovf_e;
    cnt_d   = cnt_e;
    err_d   = err_e;
    acc_d   = acc_q;
    cls     = ClsIgnored;
    offs    = '0;
    unique case (phase_e)
      PhMagic: begin
        cls = ClsMagic;
        if (pos_e == 2'd2) type_d = in_byte_i;
        if (pos_e == 2'd3) begin
          dimc_d = in_byte_i;
          pos_d  = 2'd0;
          if (elem_size(type_e) == 4'd0) begin
            err_d   = StBadType;
            phase_d = PhError;
          end else if (in_byte_i == 8'd0) begin
            cnt_d   = '0;
            phase_d = (len_e == '0) ? PhDone : PhPayload;
          end else begin
            phase_d = PhDims;
            dims_d  = 8'd0;
          end
        end else begin
          pos_d = pos_e + 2'd1;
        end
      end
      PhDims: begin
        cls   = ClsDim;
        acc_d = acc_next;
        if (pos_e == 2'd3) begin
          prod_d = acc_next[CountWidth-1:0];
          if (acc_next[AccW-1:CountWidth] != '0) ovf_d = 1'b1;
          pos_d  = 2'd0;
          dims_d = dims_e + 8'd1;
          if (dims_d >= dimc_e) begin
            cnt_d   = '0;
            phase_d = (acc_next[CountWidth-1:0] == '0) ? PhDone : PhPayload;
          end
        end else begin
          pos_d = pos_e + 2'd1;
        end
      end
      PhPayload: begin
        cls   = ClsPayload;
        offs  = cnt_e;
        cnt_d = cnt_e + CntW'(1);
        if (cnt_d >= len_e) phase_d = PhDone;
      end
      PhDone: begin
        cls = ClsTrail;
      end
      default: begin
        cls = ClsIgnored;
      end
    endcase

    // Flag truncation when the file ends early
    if (eof_i && phase_d != PhDone && phase_d != PhError) begin
      priority case (phase_d)
        PhMagic: err_d = StShortMagic;
        PhDims:  err_d = StShortDims;
        default: err_d = StShortPay;
      endcase
      phase_d = PhError;
    end

    priority if (phase_d == PhError) status = err_d;
    else if (phase_d == PhDone)      status = StDone;
    else                             status = StBusy;
  end

  // Fit the wide counts to the fixed result fields
  assign prod_ext = {32'd0, prod_d};
  assign offs_ext = {35'd0, offs};

  always_comb begin
    res_o.out_byte       = in_byte_i;
    res_o.byte_class     = cls;
    res_o.parse_status   = status;
    res_o.type_code      = type_d;
    res_o.element_size   = elem_size(type_d);
    res_o.dim_count      = dimc_d;
    res_o.element_count  = prod_ext[31:0];
    res_o.count_overflow = ovf_d;
    res_o.payload_offset = offs_ext[34:0];
  end

  // Hold state between accepted words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhMagic;
      pos_q   <= 2'd0;
      dims_q  <= 8'd0;
      type_q  <= 8'd0;
      dimc_q  <= 8'd0;
      prod_q  <= CountWidth'(1);
      ovf_q   <= 1'b0;
      cnt_q   <= '0;
      err_q   <= StBusy;
      acc_q   <= '0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      dims_q  <= dims_d;
      type_q  <= type_d;
      dimc_q  <= dimc_d;
      prod_q  <= prod_d;
      ovf_q   <= ovf_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      acc_q   <= acc_d;
    end
  end

  // Field position is clear once the whole header has been read
  a_pos_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPayload || phase_q == PhDone) |-> (pos_q == 2'd0))
    else $error("field position set after header");

  // Payload offset stays below the payload length
  a_cnt_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPayload) |-> (cnt_q < len_q))
    else $error("payload count reached length without completing");

  // Overflow flag clears only on a restart
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovf_q && !(acc_i && sof_i)) |=> ovf_q)
    else $error("overflow flag dropped without restart");

endmodule

[rtl/core/idx_header_stream_parser.sv]
// Top level of the IDX header stream parser.
// Usage:
//   in_i carries one file byte per word with start and end marks; out_o
//   returns one result word per input word, in order: the byte, its class
//   (magic, dimension, payload, trailing, ignored), the parse status and the
//   header fields kept so far, with the running element count and overflow.
//   Each result is registered, in the result register or, while out_o stalls,
//   in the skid register. Throughput is one word per cycle while in_i.ready
//   is high; the dimension product is built one byte per cycle through a
//   COUNT_WIDTH by 8 multiplier, so no byte waits on it.
//   The result register and a skid register hold up to two words; in_i.ready
//   is registered and falls only while both are full, so a stalled receiver
//   costs at most one extra accepted word before input stops.
//   Reset empties the output stage and returns parsing to the magic phase
//   with a count of one. A start mark restarts parsing on the marked byte.
module idx_header_stream_parser #(
  parameter int unsigned COUNT_WIDTH = idx_hsp_pkg::CountWidthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  idx_hsp_in_if.sink    in_i,
  idx_hsp_out_if.source out_o
);
  import idx_hsp_pkg::*;

  logic accept, skid_ready;
  res_t res, out_word;

  assign accept     = in_i.valid && skid_ready;
  assign in_i.ready = skid_ready;

  // Parse each accepted byte
  idx_hsp_parse #(
    .CountWidth (COUNT_WIDTH)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (accept),
    .in_byte_i (in_i.in_byte),
    .sof_i     (in_i.start_of_file),
    .eof_i     (in_i.end_of_file),
    .res_o     (res)
  );

  // Register results towards the receiver
  idx_hsp_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res),
    .ready_o (skid_ready),
    .valid_o (out_o.valid),
    .data_o  (out_word),
    .ready_i (out_o.ready)
  );

  // Drive result fields
  assign out_o.out_byte       = out_word.out_byte;
  assign out_o.byte_class     = out_word.byte_class;
  assign out_o.parse_status   = out_word.parse_status;
  assign out_o.type_code      = out_word.type_code;
  assign out_o.element_size   = out_word.element_size;
  assign out_o.dim_count      = out_word.dim_count;
  assign out_o.element_count  = out_word.element_count;
  assign out_o.count_overflow = out_word.count_overflow;
  assign out_o.payload_offset = out_word.payload_offset;

endmodule

[test/idx_header_stream_parser_tb.sv]
// Self-checking testbench for the IDX header stream parser: random IDX files, stalls, scoreboard.
module idx_header_stream_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import idx_hsp_pkg::*;

  localparam int unsigned CountW     = 32;
  localparam int unsigned WordTarget = 1950;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldAfter  = 600;
  localparam int unsigned HoldCycles = 400;

  // Parser phases as the scoreboard tracks them
  typedef enum logic [2:0] {PhMagic, PhDims, PhPayload, PhDone, PhError} parse_phase_e;

  // One input word: file byte with its start and end marks
  typedef struct packed {
    logic [7:0] b;
    logic       sof;
    logic       eof;
  } file_word_t;

  // Tracks the parse of the byte stream and holds the result words still due
  class idx_parse_tracker;
    parse_phase_e phase;
    logic [1:0]   field_pos;
    logic [7:0]   dims_seen;
    logic [31:0]  dim_acc;
    logic [7:0]   kept_type;
    logic [7:0]   kept_dims;
    logic [31:0]  elem_count;
    logic         overflow;
    logic [34:0]  pay_count;
    logic [2:0]   err_status;
    res_t         pending[$];
    int unsigned  mismatches;

    function new();
      restart();
      mismatches = 0;
    endfunction

    static function logic [3:0] bytes_per_elem(logic [7:0] t);
      logic [3:0] n;
      case (t)
        TypeU8, TypeS8:   n = 4'd1;
        TypeI16:          n = 4'd2;
        TypeI32, TypeF32: n = 4'd4;
        TypeF64:          n = 4'd8;
        default:          n = 4'd0;
      endcase
      return n;
    endfunction

    function void restart();
      phase      = PhMagic;
      field_pos  = '0;
      dims_seen  = '0;
      dim_acc    = '0;
      kept_type  = '0;
      kept_dims  = '0;
      elem_count = 32'd1;
      overflow   = 1'b0;
      pay_count  = '0;
      err_status = StBusy;
    endfunction

    function logic [34:0] payload_len();
      return {3'b000, elem_count} * {31'd0, bytes_per_elem(kept_type)};
    endfunction

    function void open_payload();
      pay_count = '0;
      phase = (payload_len() == '0) ? PhDone : PhPayload;
    endfunction

    // Advance the parse by one accepted word and queue its result
    function void note_byte(file_word_t w);
      res_t        r;
      logic [2:0]  cls;
      logic [34:0] offs;
      logic [63:0] wide;
      cls  = ClsIgnored;
      offs = '0;
      if (w.sof) restart();
      case (phase)
        PhMagic: begin
          cls = ClsMagic;
          if (field_pos == 2'd2) kept_type = w.b;
          if (field_pos == 2'd3) begin
            kept_dims = w.b;
            field_pos = '0;
            if (bytes_per_elem(kept_type) == 4'd0) begin
              err_status = StBadType;
              phase      = PhError;
            end else if (kept_dims == 8'd0) begin
              open_payload();
            end else begin
              phase     = PhDims;
              dims_seen = '0;
              dim_acc   = '0;
            end
          end else begin
            field_pos = field_pos + 2'd1;
          end
        end
        PhDims: begin
          cls     = ClsDim;
          dim_acc = {dim_acc[23:0], w.b};
          if (field_pos == 2'd3) begin
            // multiply in the finished dimension; any carry out is overflow
            wide = {32'd0, elem_count} * {32'd0, dim_acc};
            if (wide[63:32] != '0) overflow = 1'b1;
            elem_count = wide[31:0];
            field_pos  = '0;
            dims_seen  = dims_seen + 8'd1;
            if (dims_seen >= kept_dims) open_payload();
          end else begin
            field_pos = field_pos + 2'd1;
          end
        end
        PhPayload: begin
          cls       = ClsPayload;
          offs      = pay_count;
          pay_count = pay_count + 35'd1;
          if (pay_count >= payload_len()) phase = PhDone;
        end
        PhDone:  cls = ClsTrail;
        default: cls = ClsIgnored;
      endcase

      // end mark before completion: record which part was cut short
      if (w.eof && phase != PhDone && phase != PhError) begin
        if (phase == PhMagic) err_status = StShortMagic;
        else if (phase == PhDims) err_status = StShortDims;
        else err_status = StShortPay;
        phase = PhError;
      end

      r.out_byte       = w.b;
      r.byte_class     = cls;
      if (phase == PhError) r.parse_status = err_status;
      else if (phase == PhDone) r.parse_status = StDone;
      else r.parse_status = StBusy;
      r.type_code      = kept_type;
      r.element_size   = bytes_per_elem(kept_type);
      r.dim_count      = kept_dims;
      r.element_count  = elem_count;
      r.count_overflow = overflow;
      r.payload_offset = offs;
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one result word with the oldest one due
    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        $display("%0t: result word with nothing due, expected none, actual byte %0h",
                 $time, got.out_byte);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("byte_class", want.byte_class, got.byte_class);
      compare_field("parse_status", want.parse_status, got.parse_status);
      compare_field("type_code", want.type_code, got.type_code);
      compare_field("element_size", want.element_size, got.element_size);
      compare_field("dim_count", want.dim_count, got.dim_count);
      compare_field("element_count", want.element_count, got.element_count);
      compare_field("count_overflow", want.count_overflow, got.count_overflow);
      compare_field("payload_offset", want.payload_offset, got.payload_offset);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  idx_hsp_in_if  in_if ();
  idx_hsp_out_if out_if ();

  idx_header_stream_parser #(
    .COUNT_WIDTH (CountW)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  idx_parse_tracker tracker;
  file_word_t       file_words[$];
  int unsigned      words_sent;
  int unsigned      burst_left;
  int unsigned      cycle_count;
  logic [7:0]       valid_types[6] = '{TypeU8, TypeS8, TypeI16, TypeI32, TypeF32, TypeF64};

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Check every accepted result word
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      tracker.check_result('{out_if.out_byte, out_if.byte_class, out_if.parse_status,
                             out_if.type_code, out_if.element_size, out_if.dim_count,
                             out_if.element_count, out_if.count_overflow,
                             out_if.payload_offset});
    end
  end

  // Receiver: stall on changing patterns, with one long hold-off
  initial begin : receiver
    int unsigned rx_cycle;
    int unsigned mode;
    logic [7:0]  pattern;
    bit          held;
    out_if.ready = 1'b0;
    rx_cycle = 0;
    mode     = 0;
    pattern  = 8'hFF;
    held     = 1'b0;
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (!held && words_sent >= HoldAfter) begin
        // hold off long enough for the block to fill and stall its input
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      if (rx_cycle % 128 == 0) begin
        mode    = $urandom_range(0, 3);
        pattern = 8'($urandom_range(0, 255));
      end
      case (mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 3) != 0);
        2:       out_if.ready <= ($urandom_range(0, 1) != 0);
        default: out_if.ready <= pattern[rx_cycle % 8];
      endcase
    end
  end

  // Offer one word, idling between bursts, and hold it until accepted
  task automatic send_word(input file_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 24);
    end
    in_if.valid         <= 1'b1;
    in_if.in_byte       <= w.b;
    in_if.start_of_file <= w.sof;
    in_if.end_of_file   <= w.eof;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.note_byte(w);
    words_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic send_file();
    foreach (file_words[i]) send_word(file_words[i]);
    file_words.delete();
  endtask

  task automatic add_word(input logic [7:0] b, input logic sof, input logic eof);
    file_words.push_back('{b, sof, eof});
  endtask

  task automatic add_magic(input logic [7:0] t, input logic [7:0] n, input logic mark);
    add_word(8'($urandom_range(0, 255)), mark, 1'b0);
    add_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    add_word(t, 1'b0, 1'b0);
    add_word(n, 1'b0, 1'b0);
  endtask

  // Append a big-endian dimension
  task automatic add_dim(input logic [31:0] d);
    add_word(d[31:24], 1'b0, 1'b0);
    add_word(d[23:16], 1'b0, 1'b0);
    add_word(d[15:8], 1'b0, 1'b0);
    add_word(d[7:0], 1'b0, 1'b0);
  endtask

  task automatic add_payload(input int unsigned count);
    repeat (count) add_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
  endtask

  // Short hand-picked files covering each corner of the format
  task automatic run_directed();
    // bytes straight after reset with no start mark, one-byte payload
    add_magic(TypeU8, 8'd0, 1'b0);
    add_word(8'hAA, 1'b0, 1'b0);
    send_file();
    // unknown type; the byte after it is ignored even with its end mark
    add_magic(8'h07, 8'hFF, 1'b1);
    add_word(8'h12, 1'b0, 1'b1);
    send_file();
    // zero dimension gives an empty payload
    add_magic(TypeI32, 8'd1, 1'b1);
    add_dim(32'h0);
    send_file();
    // end mark on the very first byte
    add_word(8'h00, 1'b1, 1'b1);
    send_file();
    // payload cut short by the end mark
    add_magic(TypeI16, 8'd1, 1'b1);
    add_dim(32'h3);
    add_word(8'hFF, 1'b0, 1'b1);
    send_file();
    // restart in the middle of a payload
    add_magic(TypeF64, 8'd0, 1'b1);
    add_payload(1);
    send_file();
    // dimensions cut short
    add_magic(TypeS8, 8'd1, 1'b1);
    add_word(8'hFF, 1'b0, 1'b1);
    send_file();
  endtask

  // Build one random file: mostly well-formed, some cut short, some broken
  task automatic build_random_file();
    int unsigned kind;
    int unsigned n;
    int unsigned r;
    int unsigned a;
    int unsigned cut;
    logic [7:0]  t;
    logic [31:0] d;
    logic [63:0] prod;
    logic [34:0] len;
    logic        mark;
    kind = $urandom_range(0, 99);
    mark = ($urandom_range(0, 19) != 0);
    if (kind < 85) begin
      t    = valid_types[$urandom_range(0, 5)];
      n    = (kind < 5) ? 2 : $urandom_range(0, 3);
      a    = $urandom_range(1, 31);
      prod = 64'd1;
      add_magic(t, n[7:0], mark);
      for (int unsigned i = 0; i < n; i++) begin
        r = $urandom_range(0, 19);
        if (kind < 5) d = (i == 0) ? (32'h1 << a) : (32'h1 << (32 - a));
        else if (r < 14) d = $urandom_range(1, 4);
        else if (r == 14) d = 32'h0;
        else if (r == 15) d = 32'hFFFF_FFFF;
        else if (r == 16) d = $urandom;
        else d = 32'h1 << $urandom_range(8, 31);
        add_dim(d);
        prod = (prod * {32'd0, d}) & 64'hFFFF_FFFF;
      end
      len = {3'b000, prod[31:0]} * {31'd0, idx_parse_tracker::bytes_per_elem(t)};
      if (len > 35'd96) begin
        // too long to send whole: stop part way through the payload
        add_payload($urandom_range(0, 12));
        file_words[file_words.size() - 1].eof = 1'b1;
      end else if (kind >= 70) begin
        add_payload(32'(len));
        cut = $urandom_range(1, file_words.size());
        file_words = file_words[0:cut-1];
        file_words[file_words.size() - 1].eof = 1'b1;
      end else begin
        add_payload(32'(len));
        add_payload($urandom_range(0, 2));
        if ($urandom_range(0, 3) != 0) file_words[file_words.size() - 1].eof = 1'b1;
      end
    end else if (kind < 93) begin
      do t = 8'($urandom_range(0, 255));
      while (idx_parse_tracker::bytes_per_elem(t) != 4'd0);
      add_magic(t, 8'($urandom_range(0, 255)), mark);
      add_payload($urandom_range(0, 3));
      file_words[file_words.size() - 1].eof = ($urandom_range(0, 1) != 0);
    end else begin
      // noise with occasional marks
      repeat ($urandom_range(1, 6)) begin
        add_word(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0),
                 ($urandom_range(0, 7) == 0));
      end
    end
  endtask

  // Main sequence
  initial begin
    tracker             = new();
    words_sent          = 0;
    burst_left          = 0;
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.in_byte       = 8'h00;
    in_if.start_of_file = 1'b0;
    in_if.end_of_file   = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    while (words_sent < WordTarget) begin
      build_random_file();
      send_file();
    end
    in_if.valid <= 1'b0;

    // drain, then allow for the output stage latency
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
